// ----- rtl/core/c8ie_pkg.sv -----
`default_nettype none
package c8ie_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EXEC    = 2'd1,
    OP_COLL    = 2'd2,
    OP_NONE    = 2'd3
  } op_code_t;

  typedef enum logic [2:0] {
    KIND_EXEC  = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_DRAW  = 3'd2,
    KIND_IGN   = 3'd3,
    KIND_ACK   = 3'd4
  } kind_code_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [7:0]  random_byte;
    logic        collision;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] pc_now;
    logic [11:0] sprite_address;
    logic [3:0]  sprite_rows;
    logic [7:0]  sprite_x;
    logic [7:0]  sprite_y;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FONT,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_DECODE,
    ST_EXEC,
    ST_BCD,
    ST_SAVE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_DONE
  } state_t;

  localparam logic [11:0] PC_START  = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam int unsigned FONT_LEN  = 80;

  function automatic logic [7:0] font_byte(input logic [6:0] i);
    logic [7:0] g [0:79];
    g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
          8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
          8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
          8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
          8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
          8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
          8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
          8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
    return (i < 7'd80) ? g[i] : 8'h00;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/c8ie_ram.sv -----
`default_nettype none
module c8ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/chip8_instruction_executor_core.sv -----
`default_nettype none
// each request is accepted from idle; load and collision go straight to the result state;
//   execute fetches both opcode bytes, decodes and executes, and BCD, Fx55 and Fx65 add
//   their byte steps, all through one byte memory port
// handshake: one request at a time, busy high until the result strobe ends,
//   so a new request is taken only once the core is back in idle
// reset: 80-byte font copy into main memory at 0x050 while busy stays high;
//   registers clear, pc to 0x200; results cannot be stalled by the receiver
module chip8_instruction_executor_core #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire c8ie_pkg::req_t   req,
  output logic                  busy,
  output logic                  done,
  output c8ie_pkg::rsp_t        rsp
);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);

  c8ie_pkg::state_t state, state_next;
  c8ie_pkg::req_t   cur;
  logic [11:0] pc;
  logic [15:0] ireg;
  logic [SPW-1:0] sp;
  logic [7:0]  vreg [16];
  logic [11:0] stk [STACK_DEPTH];
  logic [7:0]  delay_value, sound_value;
  logic [15:0] w;
  logic [6:0]  fcnt;
  logic [4:0]  k;
  logic [2:0]  kind;
  logic [1:0]  bcd_i;

  // memory port
  logic        m_we;
  logic [11:0] m_wa, m_ra;
  logic [7:0]  m_wd, m_rd;

  c8ie_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  logic [3:0] x, y;
  logic [7:0] kk, vx, vy, v0;
  assign x  = w[11:8];
  assign y  = w[7:4];
  assign kk = w[7:0];
  assign vx = vreg[x];
  assign vy = vreg[y];
  assign v0 = vreg[0];

  // bcd digits
  logic [7:0] hund, tens, ones, rem1;
  always_comb begin
    hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    rem1 = vx - 8'(hund * 8'd100);
    tens = 8'((16'(rem1) * 16'd205) >> 11);
    ones = rem1 - 8'(tens * 8'd10);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      c8ie_pkg::ST_FONT:
        if (fcnt == 7'(c8ie_pkg::FONT_LEN - 1)) state_next = c8ie_pkg::ST_IDLE;
      c8ie_pkg::ST_IDLE:
        if (start) state_next = (req.op == c8ie_pkg::OP_EXEC) ?
                                 c8ie_pkg::ST_FETCH_HI : c8ie_pkg::ST_DONE;
      c8ie_pkg::ST_FETCH_HI: state_next = c8ie_pkg::ST_FETCH_LO;
      c8ie_pkg::ST_FETCH_LO: state_next = c8ie_pkg::ST_DECODE;
      c8ie_pkg::ST_DECODE:   state_next = c8ie_pkg::ST_EXEC;
      c8ie_pkg::ST_EXEC: begin
        state_next = c8ie_pkg::ST_DONE;
        if (w[15:12] == 4'hF && kk == 8'h33) state_next = c8ie_pkg::ST_BCD;
        if (w[15:12] == 4'hF && kk == 8'h55) state_next = c8ie_pkg::ST_SAVE;
        if (w[15:12] == 4'hF && kk == 8'h65) state_next = c8ie_pkg::ST_LOAD_RD;
      end
      c8ie_pkg::ST_BCD:
        if (bcd_i == 2'd2) state_next = c8ie_pkg::ST_DONE;
      c8ie_pkg::ST_SAVE:
        if (k[3:0] == x) state_next = c8ie_pkg::ST_DONE;
      c8ie_pkg::ST_LOAD_RD: state_next = c8ie_pkg::ST_LOAD_WR;
      c8ie_pkg::ST_LOAD_WR:
        state_next = (k[3:0] == x) ? c8ie_pkg::ST_DONE : c8ie_pkg::ST_LOAD_RD;
      c8ie_pkg::ST_DONE: state_next = c8ie_pkg::ST_IDLE;
      default: state_next = c8ie_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    m_we = 1'b0;
    m_wa = req.load_address;
    m_wd = req.load_data;
    m_ra = pc;
    unique case (state)
      c8ie_pkg::ST_FONT: begin
        m_we = 1'b1;
        m_wa = c8ie_pkg::FONT_BASE + 12'(fcnt);
        m_wd = c8ie_pkg::font_byte(fcnt);
      end
      c8ie_pkg::ST_IDLE: begin
        m_we = start && (req.op == c8ie_pkg::OP_LOAD);
        m_ra = pc;
      end
      c8ie_pkg::ST_FETCH_HI: m_ra = pc + 12'd1;
      c8ie_pkg::ST_BCD: begin
        m_we = 1'b1;
        m_wa = ireg[11:0] + 12'(bcd_i);
        m_wd = (bcd_i == 2'd0) ? hund : (bcd_i == 2'd1) ? tens : ones;
      end
      c8ie_pkg::ST_SAVE: begin
        m_we = 1'b1;
        m_wa = ireg[11:0] + 12'(k);
        m_wd = vreg[k[3:0]];
      end
      c8ie_pkg::ST_LOAD_RD: m_ra = ireg[11:0] + 12'(k);
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != c8ie_pkg::ST_IDLE);
    done = (state == c8ie_pkg::ST_DONE);
    rsp  = '0;
    rsp.kind   = kind;
    rsp.pc_now = pc;
    if (kind == c8ie_pkg::KIND_DRAW) begin
      rsp.sprite_address = ireg[11:0];
      rsp.sprite_rows    = w[3:0];
      rsp.sprite_x       = vx;
      rsp.sprite_y       = vy;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) state <= c8ie_pkg::ST_FONT;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= '0; pc <= c8ie_pkg::PC_START; ireg <= '0; sp <= '0;
      delay_value <= '0; sound_value <= '0; kind <= c8ie_pkg::KIND_ACK;
      for (int i = 0; i < 16; i++) vreg[i] <= '0;
    end else begin
      unique case (state)
        c8ie_pkg::ST_FONT: fcnt <= fcnt + 7'd1;
        c8ie_pkg::ST_IDLE:
          if (start) begin
            cur <= req;
            kind <= c8ie_pkg::KIND_ACK;
            if (req.op == c8ie_pkg::OP_COLL) vreg[15] <= {7'd0, req.collision};
            if (req.op == c8ie_pkg::OP_NONE) kind <= c8ie_pkg::KIND_IGN;
          end
        c8ie_pkg::ST_FETCH_HI: w[15:8] <= m_rd;
        c8ie_pkg::ST_FETCH_LO: w[7:0] <= m_rd;
        c8ie_pkg::ST_DECODE: begin
          pc <= pc + 12'd2;
          k <= '0; bcd_i <= '0;
          kind <= c8ie_pkg::KIND_EXEC;
        end
        c8ie_pkg::ST_EXEC: begin
          unique case (w[15:12])
            4'h0:
              if (w == 16'h00E0) kind <= c8ie_pkg::KIND_CLEAR;
              else if (w == 16'h00EE && sp != '0) begin
                sp <= sp - SPW'(1);
                pc <= stk[SAW'(sp - SPW'(1))];
              end else kind <= c8ie_pkg::KIND_IGN;
            4'h1: pc <= w[11:0];
            4'h2:
              if (sp < SPW'(STACK_DEPTH)) begin
                stk[SAW'(sp)] <= pc;
                sp <= sp + SPW'(1);
                pc <= w[11:0];
              end else kind <= c8ie_pkg::KIND_IGN;
            4'h3: if (vx == kk) pc <= pc + 12'd2;
            4'h4: if (vx != kk) pc <= pc + 12'd2;
            4'h5: if (vx == vy) pc <= pc + 12'd2;
            4'h6: vreg[x] <= kk;
            4'h7: vreg[x] <= vx + kk;
            4'h8:
              // flag forms: vf takes the flag when it is also the destination
              case (w[3:0])
                4'h0: vreg[x] <= vy;
                4'h1: vreg[x] <= vx | vy;
                4'h2: vreg[x] <= vx & vy;
                4'h3: vreg[x] <= vx ^ vy;
                4'h4: begin
                  if (x != 4'hF) vreg[x] <= vx + vy;
                  vreg[15] <= {7'd0, (9'(vx) + 9'(vy)) > 9'd255};
                end
                4'h5: begin
                  if (x != 4'hF) vreg[x] <= vx - vy;
                  vreg[15] <= {7'd0, vx >= vy};
                end
                4'h6: begin
                  if (x != 4'hF) vreg[x] <= vx >> 1;
                  vreg[15] <= {7'd0, vx[0]};
                end
                4'h7: begin
                  if (x != 4'hF) vreg[x] <= vy - vx;
                  vreg[15] <= {7'd0, vy >= vx};
                end
                4'hE: begin
                  if (x != 4'hF) vreg[x] <= vx << 1;
                  vreg[15] <= {7'd0, vx[7]};
                end
                default: kind <= c8ie_pkg::KIND_IGN;
              endcase
            4'h9: if (vx != vy) pc <= pc + 12'd2;
            4'hA: ireg <= {4'd0, w[11:0]};
            4'hB: pc <= w[11:0] + 12'(v0);
            4'hC: vreg[x] <= cur.random_byte & kk;
            4'hD: kind <= c8ie_pkg::KIND_DRAW;
            4'hE: if (kk != 8'h9E && kk != 8'hA1) kind <= c8ie_pkg::KIND_IGN;
            default:
              case (kk)
                8'h07: vreg[x] <= delay_value;
                8'h0A, 8'h33, 8'h55, 8'h65: ;
                8'h15: delay_value <= vx;
                8'h18: sound_value <= vx;
                8'h1E: ireg <= ireg + 16'(vx);
                8'h29: ireg <= 16'(c8ie_pkg::FONT_BASE) + 16'(vx) * 16'd5;
                default: kind <= c8ie_pkg::KIND_IGN;
              endcase
          endcase
        end
        c8ie_pkg::ST_BCD: bcd_i <= bcd_i + 2'd1;
        c8ie_pkg::ST_SAVE: k <= k + 5'd1;
        c8ie_pkg::ST_LOAD_WR: begin
          vreg[k[3:0]] <= m_rd;
          k <= k + 5'd1;
        end
        default: ;
      endcase
    end
  end

  // checks
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe without busy");
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH)) else $error("stack pointer overflow");
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double result");
  a_start_fetch: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.op == c8ie_pkg::OP_EXEC) |=> state == c8ie_pkg::ST_FETCH_HI)
    else $error("execute did not fetch");
endmodule
`default_nettype wire

// ----- verif/chip8_instruction_executor_core_test.sv -----
module chip8_instruction_executor_core_test;

  logic clk;
  logic rst;
  logic start;
  c8ie_pkg::req_t req;
  logic busy;
  logic done;
  c8ie_pkg::rsp_t rsp;

  chip8_instruction_executor_core u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .rsp(rsp)
  );

  localparam logic [7:0] GLYPHS [80] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};

  // shadow copy of the machine
  logic [7:0]  shadow_mem [4096];
  bit          mem_known [4096];
  logic [7:0]  vreg [16];
  logic [11:0] ret_stack [16];
  int          stack_used;
  logic [11:0] cur_pc;
  logic [15:0] index_val;
  logic [7:0]  delay_val;
  logic [7:0]  sound_val;

  c8ie_pkg::rsp_t expected_rsp [$];
  int   mismatches;
  int   idle_pct;
  int   requests_sent;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void write_byte(logic [11:0] a, logic [7:0] d);
    shadow_mem[a] = d;
    mem_known[a] = 1'b1;
  endfunction

  // advance the shadow machine by one request and return its response
  function automatic c8ie_pkg::rsp_t predict_step(c8ie_pkg::req_t r);
    c8ie_pkg::rsp_t o;
    logic [15:0] w;
    logic [3:0] x, y;
    logic [7:0] kk, vx, vy;
    logic [11:0] nnn;
    logic [8:0] sum;
    int k;
    o = '0;
    o.kind = c8ie_pkg::KIND_ACK;
    case (c8ie_pkg::op_code_t'(r.op))
      c8ie_pkg::OP_LOAD: write_byte(r.load_address, r.load_data);
      c8ie_pkg::OP_COLL: vreg[15] = {7'd0, r.collision};
      c8ie_pkg::OP_NONE: o.kind = c8ie_pkg::KIND_IGN;
      default: begin
        w = {shadow_mem[cur_pc], shadow_mem[cur_pc + 12'd1]};
        cur_pc = cur_pc + 12'd2;
        x = w[11:8];
        y = w[7:4];
        kk = w[7:0];
        nnn = w[11:0];
        vx = vreg[x];
        vy = vreg[y];
        o.kind = c8ie_pkg::KIND_EXEC;
        case (w[15:12])
          4'h0: begin
            if (w == 16'h00E0) begin
              o.kind = c8ie_pkg::KIND_CLEAR;
            end else if (w == 16'h00EE && stack_used > 0) begin
              stack_used--;
              cur_pc = ret_stack[stack_used];
            end else begin
              o.kind = c8ie_pkg::KIND_IGN;
            end
          end
          4'h1: cur_pc = nnn;
          4'h2: begin
            if (stack_used < 16) begin
              ret_stack[stack_used] = cur_pc;
              stack_used++;
              cur_pc = nnn;
            end else begin
              o.kind = c8ie_pkg::KIND_IGN;
            end
          end
          4'h3: if (vx == kk) cur_pc = cur_pc + 12'd2;
          4'h4: if (vx != kk) cur_pc = cur_pc + 12'd2;
          4'h5: if (vx == vy) cur_pc = cur_pc + 12'd2;
          4'h6: vreg[x] = kk;
          4'h7: vreg[x] = vx + kk;
          4'h8: begin
            // result lands in vx first, flag last
            case (w[3:0])
              4'h0: vreg[x] = vy;
              4'h1: vreg[x] = vx | vy;
              4'h2: vreg[x] = vx & vy;
              4'h3: vreg[x] = vx ^ vy;
              4'h4: begin
                sum = {1'b0, vx} + {1'b0, vy};
                vreg[x] = sum[7:0];
                vreg[15] = {7'd0, sum[8]};
              end
              4'h5: begin
                vreg[x] = vx - vy;
                vreg[15] = {7'd0, vx >= vy};
              end
              4'h6: begin
                vreg[x] = vx >> 1;
                vreg[15] = {7'd0, vx[0]};
              end
              4'h7: begin
                vreg[x] = vy - vx;
                vreg[15] = {7'd0, vy >= vx};
              end
              4'hE: begin
                vreg[x] = vx << 1;
                vreg[15] = {7'd0, vx[7]};
              end
              default: o.kind = c8ie_pkg::KIND_IGN;
            endcase
          end
          4'h9: if (vx != vy) cur_pc = cur_pc + 12'd2;
          4'hA: index_val = {4'd0, nnn};
          4'hB: cur_pc = nnn + {4'd0, vreg[0]};
          4'hC: vreg[x] = r.random_byte & kk;
          4'hD: begin
            o.kind = c8ie_pkg::KIND_DRAW;
            o.sprite_address = index_val[11:0];
            o.sprite_rows = w[3:0];
            o.sprite_x = vx;
            o.sprite_y = vy;
          end
          4'hE: if (kk != 8'h9E && kk != 8'hA1) o.kind = c8ie_pkg::KIND_IGN;
          default: begin
            case (kk)
              8'h07: vreg[x] = delay_val;
              8'h0A: ;
              8'h15: delay_val = vx;
              8'h18: sound_val = vx;
              8'h1E: index_val = index_val + {8'd0, vx};
              8'h29: index_val = {4'd0, c8ie_pkg::FONT_BASE} + 16'd5 * {8'd0, vx};
              8'h33: begin
                write_byte(index_val[11:0], vx / 8'd100);
                write_byte(index_val[11:0] + 12'd1, (vx / 8'd10) % 8'd10);
                write_byte(index_val[11:0] + 12'd2, vx % 8'd10);
              end
              8'h55: for (k = 0; k <= x; k++) write_byte(12'(index_val[11:0] + k), vreg[k]);
              8'h65: for (k = 0; k <= x; k++) vreg[k] = shadow_mem[12'(index_val[11:0] + k)];
              default: o.kind = c8ie_pkg::KIND_IGN;
            endcase
          end
        endcase
      end
    endcase
    o.pc_now = cur_pc;
    return o;
  endfunction

  // one request through the start/busy handshake
  task automatic send_req(c8ie_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rsp.push_back(predict_step(r));
    requests_sent++;
  endtask

  task automatic send_op(c8ie_pkg::op_code_t op, logic [11:0] a, logic [7:0] d);
    c8ie_pkg::req_t r;
    r = c8ie_pkg::req_t'(31'({$urandom, $urandom}));
    r.op = op;
    r.load_address = a;
    r.load_data = d;
    send_req(r);
  endtask

  task automatic put_word(logic [11:0] a, logic [15:0] w);
    send_op(c8ie_pkg::OP_LOAD, a, w[15:8]);
    send_op(c8ie_pkg::OP_LOAD, a + 12'd1, w[7:0]);
  endtask

  // execute at pc, first filling any byte it would read that was never written
  task automatic exec_next();
    logic [15:0] w;
    int k;
    if (!mem_known[cur_pc] || !mem_known[cur_pc + 12'd1])
      put_word(cur_pc, 16'({$urandom}));
    w = {shadow_mem[cur_pc], shadow_mem[cur_pc + 12'd1]};
    if (w[15:12] == 4'hF && w[7:0] == 8'h65) begin
      for (k = 0; k <= w[11:8]; k++)
        if (!mem_known[12'(index_val[11:0] + k)])
          send_op(c8ie_pkg::OP_LOAD, 12'(index_val[11:0] + k), 8'($urandom));
    end
    send_op(c8ie_pkg::OP_EXEC, 12'($urandom), 8'($urandom));
  endtask

  task automatic run_word(logic [15:0] w);
    put_word(cur_pc, w);
    exec_next();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] gen_word();
    logic [3:0] cls;
    logic [11:0] body;
    logic [7:0] misc_codes [9];
    misc_codes = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
    cls = 4'($urandom);
    body = 12'($urandom);
    case (cls)
      4'h0: begin
        case ($urandom_range(3))
          0: return 16'h00E0;
          1, 2: return 16'h00EE;
          default: return {4'h0, body};
        endcase
      end
      4'h8: begin
        if ($urandom_range(4) == 0) return {4'h8, body};
        return {4'h8, body[11:4], ($urandom_range(8) == 8) ? 4'hE : 4'($urandom_range(7))};
      end
      4'hE: begin
        case ($urandom_range(2))
          0: return {4'hE, body[11:8], 8'h9E};
          1: return {4'hE, body[11:8], 8'hA1};
          default: return {4'hE, body};
        endcase
      end
      4'hF: begin
        if ($urandom_range(5) == 0) return {4'hF, body};
        return {4'hF, body[11:8], misc_codes[$urandom_range(8)]};
      end
      default: return {cls, body};
    endcase
  endfunction

  // response checker
  always @(posedge clk) begin
    c8ie_pkg::rsp_t exp_r;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (rsp.kind !== exp_r.kind || rsp.pc_now !== exp_r.pc_now ||
            rsp.sprite_address !== exp_r.sprite_address ||
            rsp.sprite_rows !== exp_r.sprite_rows ||
            rsp.sprite_x !== exp_r.sprite_x || rsp.sprite_y !== exp_r.sprite_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_r, rsp);
        end
      end
    end
  end

  // plain items: ignored op, collisions, loads at the address extremes
  task automatic test_item_ops();
    send_op(c8ie_pkg::OP_NONE, 12'hFFF, 8'hFF);
    send_op(c8ie_pkg::OP_COLL, 12'h000, 8'h00);
    send_op(c8ie_pkg::OP_LOAD, 12'hFFF, 8'hA5);
    send_op(c8ie_pkg::OP_LOAD, 12'h000, 8'h5A);
  endtask

  // arithmetic flags, including vf as destination
  task automatic test_alu();
    run_word(16'h60FF);
    run_word(16'h6101);
    run_word(16'h8014);
    run_word(16'h6201);
    run_word(16'h8125);
    run_word(16'h8217);
    run_word(16'h8206);
    run_word(16'h60FF);
    run_word(16'h800E);
    run_word(16'h6F80);
    run_word(16'h8FFE);
    run_word(16'h8F14);
    run_word(16'h8018);
    run_word(16'h7FFF);
  endtask

  // skips, jumps with wrap, a full and an empty return stack
  task automatic test_flow();
    int k;
    run_word(16'h6005);
    run_word(16'h3005);
    run_word(16'h4005);
    run_word(16'h51A3);
    run_word(16'h91A7);
    run_word(16'h1FFE);
    run_word(16'h6000);
    run_word(16'hBFFE);
    for (k = 0; k < 17; k++) run_word({4'h2, cur_pc + 12'd2});
    for (k = 0; k < 17; k++) run_word(16'h00EE);
  endtask

  // index, bcd, register save and load wrapping past the top of memory, plus draw, clear, key and timer forms
  task automatic test_index_mem();
    run_word(16'h60FF);
    run_word(16'hF029);
    run_word(16'hD01F);
    run_word(16'hAFFE);
    run_word(16'hF033);
    run_word(16'hFF55);
    run_word(16'hFF65);
    run_word(16'h00E0);
    run_word(16'hE39E);
    run_word(16'hE3A1);
    run_word(16'hE312);
    run_word(16'hF00A);
    run_word(16'hF015);
    run_word(16'hF018);
    run_word(16'hF107);
    run_word(16'hF0FF);
    run_word(16'h0123);
    run_word(16'hC2FF);
    run_word(16'hC30F);
  endtask

  // index register wraps past 0xFFFF through repeated adds
  task automatic test_index_wrap();
    logic [11:0] loop_at;
    int k;
    run_word(16'h60FF);
    run_word(16'hAFFF);
    loop_at = cur_pc;
    put_word(loop_at, 16'hF01E);
    put_word(loop_at + 12'd2, {4'h1, loop_at});
    for (k = 0; k < 2 * 245; k++) exec_next();
    run_word(16'hD000);
  endtask

  task automatic test_random(int pct, int n);
    int first;
    int pick;
    idle_pct = pct;
    first = requests_sent;
    while (requests_sent - first < n) begin
      pick = $urandom_range(99);
      if (pick < 6) send_op(c8ie_pkg::OP_LOAD, 12'($urandom), 8'($urandom));
      else if (pick < 8) send_op(c8ie_pkg::OP_COLL, 12'($urandom), 8'($urandom));
      else if (pick < 9) send_op(c8ie_pkg::OP_NONE, 12'($urandom), 8'($urandom));
      else if (pick < 10) wait_drained();
      else if (pick < 75) run_word(gen_word());
      else exec_next();
    end
  endtask

  initial begin
    int k;
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    mismatches = 0;
    requests_sent = 0;
    idle_pct = 22;
    for (k = 0; k < 4096; k++) begin
      shadow_mem[k] = 8'h00;
      mem_known[k] = 1'b0;
    end
    for (k = 0; k < 80; k++) write_byte(12'(c8ie_pkg::FONT_BASE + k), GLYPHS[k]);
    for (k = 0; k < 16; k++) vreg[k] = 8'h00;
    stack_used = 0;
    cur_pc = c8ie_pkg::PC_START;
    index_val = 16'h0000;
    delay_val = 8'h00;
    sound_val = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_item_ops();
    test_alu();
    test_flow();
    test_index_mem();
    test_index_wrap();
    wait_drained();
    test_random(22, 190);
    test_random(76, 190);
    test_random(0, 190);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
